// ===== hw/rtl/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared constants, codes and controller/datapath handshake types for the
// complex I/Q FIR decimator.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int MAX_TAPS       = 64;
  localparam int COEF_FRAC_BITS = 15;
  localparam int MAX_DECIMATION = 256;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int TAP_IDX_W = $clog2(MAX_TAPS);        // delay / coef address
  localparam int TAP_CNT_W = 7;                       // tap_count register
  localparam int DECIM_W   = 9;                       // decimation register
  localparam int PHASE_W   = 8;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + TAP_IDX_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DECIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'd1;

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // controller -> datapath
  typedef struct packed {
    logic take_sample;  // sample item accepted this cycle
    logic take_coef;    // coefficient item accepted this cycle
    logic start_mac;    // accepted sample closes a decimation period
    logic issue;        // issue one tap read
    logic load_out;     // move finished sums into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;         // next sample completes the phase count
    logic last_issue;   // current tap is the last one
    logic pipe_busy;    // products still in flight
    logic out_free;     // output register can take a result now
  } sts_t;

endpackage

// ===== hw/rtl/ifd_in_if.sv =====
// ----------------------------------------------------------------------------
// ifd_in_if
// Input item channel: valid/ready plus sample or coefficient-write payload.
// ----------------------------------------------------------------------------
interface ifd_in_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  ifd_pkg::sample_t       sample_i;
  ifd_pkg::sample_t       sample_q;
  logic [5:0]             coef_index;
  ifd_pkg::coef_t         coef_value;

  modport source (output valid, req_type, sample_i, sample_q, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, req_type, sample_i, sample_q, coef_index, coef_value,
                  output ready);
endinterface

// ===== hw/rtl/ifd_out_if.sv =====
// ----------------------------------------------------------------------------
// ifd_out_if
// Result item channel: valid/ready plus filtered I/Q pair.
// ----------------------------------------------------------------------------
interface ifd_out_if;
  logic             valid;
  logic             ready;
  ifd_pkg::sample_t out_i;
  ifd_pkg::sample_t out_q;

  modport source (output valid, out_i, out_q, input ready);
  modport sink   (input valid, out_i, out_q, output ready);
endinterface

// ===== hw/rtl/iq_fir_decimator_top.sv =====
// ----------------------------------------------------------------------------
// iq_fir_decimator_top
// Complex I/Q FIR decimator, 16-bit samples, Q1.15 coefficients.
// ----------------------------------------------------------------------------
// Each sample item writes an I/Q pair into a circular delay line of tap_count
// entries; every decimation-th sample starts a filter pass that runs one MAC
// per rail per cycle over the newest tap_count samples, then rounds (half to
// even) and saturates to 16 bits. Coefficient items load the coefficient RAM.
// A sample item that does not close a decimation period leaves the block idle;
// one that does runs a filter pass: accept, tap_count reads from the
// delay/coefficient RAMs through their single read port, a drain while the
// last read is multiplied, accumulated and the pipe is seen empty, then the
// output register load, waiting for a previous result to be taken. While the
// pass runs in_ready is low. The result sits in an output register,
// so new items are accepted while it waits. Delay lines read as zero after
// reset (per-entry valid bits, no clearing pass); coefficients must be written
// before use. Configuration (cfg_index 0 = decimation, 1 = tap_count) may
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module iq_fir_decimator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ifd_in_if.sink                          in_ch,
  ifd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ifd_pkg::cmd_t cmd;   // sequencer commands
  ifd_pkg::sts_t sts;   // datapath status
  logic          in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: item accept, tap loop, drain, output hand-off
  ifd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // storage, counters, MACs and output register
  ifd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_i   (in_ch.sample_i),
    .sample_q   (in_ch.sample_q),
    .coef_index (in_ch.coef_index),
    .coef_value (in_ch.coef_value),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_i      (out_ch.out_i),
    .out_q      (out_ch.out_q)
  );

endmodule

// ===== hw/rtl/ifd_ram.sv =====
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ifd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifd_ctrl
// Sequencer: accepts items, runs the tap loop, drains the MAC pipe and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module ifd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_ready,
  input  ifd_pkg::sts_t sts,
  output ifd_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    state_nxt       = state_r;
    cmd.take_sample = accept && (in_req_type == ifd_pkg::REQ_SAMPLE);
    cmd.take_coef   = accept && (in_req_type == ifd_pkg::REQ_COEF);
    cmd.start_mac   = cmd.take_sample && sts.emit;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start_mac) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/ifd_datapath.sv =====
// ----------------------------------------------------------------------------
// ifd_datapath
// Config registers, delay and coefficient RAMs, slot/phase/tap counters,
// one MAC per rail, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module ifd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ifd_pkg::cmd_t                    cmd,
  output ifd_pkg::sts_t                    sts,
  input  logic                             cfg_we,
  input  logic [ifd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ifd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  ifd_pkg::sample_t                 sample_i,
  input  ifd_pkg::sample_t                 sample_q,
  input  logic [ifd_pkg::TAP_IDX_W-1:0]    coef_index,
  input  ifd_pkg::coef_t                   coef_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ifd_pkg::sample_t                 out_i,
  output ifd_pkg::sample_t                 out_q
);

  localparam int IW = ifd_pkg::TAP_IDX_W;
  localparam int AW = ifd_pkg::ACC_W;
  localparam int SW = ifd_pkg::SAMPLE_W;
  localparam int FB = ifd_pkg::COEF_FRAC_BITS;
  localparam logic signed [AW-1:0] ACC_HI = AW'(32767 * (2 ** FB));
  localparam logic signed [AW-1:0] ACC_LO = AW'(-32768 * (2 ** FB));
  localparam logic [FB-1:0]        HALF   = FB'(1) << (FB - 1);

  // saturate, then round half to even out of Q.FB
  function automatic ifd_pkg::sample_t finish(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    logic [FB-1:0]        rem;
    logic                 up;
    t   = acc >>> FB;
    rem = acc[FB-1:0];
    up  = (rem > HALF) || ((rem == HALF) && t[0]);
    if (acc >= ACC_HI) begin
      finish = 16'sh7FFF;
    end else if (acc <= ACC_LO) begin
      finish = 16'sh8000;
    end else begin
      finish = t[SW-1:0] + SW'(up);
    end
  endfunction

  // ---- configuration ----
  logic [ifd_pkg::DECIM_W-1:0]   decim_r;
  logic [ifd_pkg::TAP_CNT_W-1:0] taps_r;
  logic [ifd_pkg::TAP_CNT_W-1:0] n_eff;
  logic [ifd_pkg::DECIM_W-1:0]   m_eff;
  logic [IW-1:0]                 n_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r <= ifd_pkg::DECIM_W'(1);
      taps_r  <= ifd_pkg::TAP_CNT_W'(ifd_pkg::MAX_TAPS);
    end else if (cfg_we) begin
      case (cfg_index)
        ifd_pkg::CFG_DECIMATION: decim_r <= cfg_data;
        ifd_pkg::CFG_TAP_COUNT:  taps_r  <= cfg_data[ifd_pkg::TAP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (taps_r == '0) begin
      n_eff = ifd_pkg::TAP_CNT_W'(1);
    end else if (taps_r > ifd_pkg::TAP_CNT_W'(ifd_pkg::MAX_TAPS)) begin
      n_eff = ifd_pkg::TAP_CNT_W'(ifd_pkg::MAX_TAPS);
    end else begin
      n_eff = taps_r;
    end
    if (decim_r == '0) begin
      m_eff = ifd_pkg::DECIM_W'(1);
    end else if (decim_r > ifd_pkg::DECIM_W'(ifd_pkg::MAX_DECIMATION)) begin
      m_eff = ifd_pkg::DECIM_W'(ifd_pkg::MAX_DECIMATION);
    end else begin
      m_eff = decim_r;
    end
  end

  assign n_m1 = IW'(n_eff - ifd_pkg::TAP_CNT_W'(1));

  // ---- write slot and phase ----
  logic [IW-1:0]                 ws_r, ws_nxt, newest;
  logic [ifd_pkg::TAP_CNT_W-1:0] ws_inc;
  logic [ifd_pkg::PHASE_W-1:0]   ph_r;
  logic [ifd_pkg::PHASE_W:0]     ph_inc;

  assign ws_inc   = ifd_pkg::TAP_CNT_W'(ws_r) + ifd_pkg::TAP_CNT_W'(1);
  assign ws_nxt   = (ws_inc >= n_eff) ? '0 : ws_inc[IW-1:0];
  assign newest   = (ws_nxt == '0) ? n_m1 : ws_nxt - IW'(1);
  assign ph_inc   = {1'b0, ph_r} + (ifd_pkg::PHASE_W + 1)'(1);
  assign sts.emit = (ph_inc >= m_eff);

  // delay-line valid bits: unwritten entries read as zero
  logic [ifd_pkg::MAX_TAPS-1:0] dvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      ph_r   <= '0;
      dvld_r <= '0;
    end else if (cmd.take_sample) begin
      ws_r         <= ws_nxt;
      ph_r         <= sts.emit ? '0 : ph_inc[ifd_pkg::PHASE_W-1:0];
      dvld_r[ws_r] <= 1'b1;
    end
  end

  // ---- storage ----
  logic [IW-1:0]     tap_r, idx_r;
  logic [2*SW-1:0]   dly_rd;
  logic [SW-1:0]     coef_rd;

  ifd_ram #(.WIDTH(2 * SW), .DEPTH(ifd_pkg::MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (cmd.take_sample),
    .waddr (ws_r),
    .wdata ({sample_i, sample_q}),
    .raddr (idx_r),
    .rdata (dly_rd)
  );

  ifd_ram #(.WIDTH(ifd_pkg::COEF_W), .DEPTH(ifd_pkg::MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.take_coef),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr (tap_r),
    .rdata (coef_rd)
  );

  // ---- tap sequencing ----
  assign sts.last_issue = (tap_r == n_m1);

  always_ff @(posedge clk) begin
    if (cmd.start_mac) begin
      tap_r <= '0;
      idx_r <= newest;
    end else if (cmd.issue) begin
      tap_r <= tap_r + IW'(1);
      idx_r <= (idx_r == '0) ? n_m1 : idx_r - IW'(1);
    end
  end

  // ---- MAC pipe: read -> multiply -> accumulate ----
  logic                               rd_v_r, mul_v_r, dv_r;
  ifd_pkg::sample_t                   di, dq;
  ifd_pkg::coef_t                     cf;
  logic signed [ifd_pkg::PROD_W-1:0]  prod_i_r, prod_q_r;
  logic signed [AW-1:0]               acc_i_r, acc_q_r;

  assign di = dv_r ? dly_rd[2*SW-1:SW] : '0;
  assign dq = dv_r ? dly_rd[SW-1:0]    : '0;
  assign cf = coef_rd;
  assign sts.pipe_busy = rd_v_r || mul_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_r     <= dvld_r[idx_r];
    prod_i_r <= cf * di;
    prod_q_r <= cf * dq;
    if (cmd.start_mac) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (mul_v_r) begin
      acc_i_r <= acc_i_r + AW'(prod_i_r);
      acc_q_r <= acc_q_r + AW'(prod_q_r);
    end
  end

  // ---- output register ----
  logic             out_v_r;
  ifd_pkg::sample_t out_i_r, out_q_r;

  assign sts.out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_i_r <= finish(acc_i_r);
      out_q_r <= finish(acc_q_r);
    end
  end

  assign out_valid = out_v_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule

// ===== test/iq_fir_decimator_top_test.sv =====
// ----------------------------------------------------------------------------
// iq_fir_decimator_top_test
// Self-checking bench for the complex I/Q FIR decimator: a directed table of
// extreme, saturating and round-to-even items, then random sample and tap
// items over several decimation / tap_count settings, checked item by item
// against a bit-true filter predictor under random sender and receiver idling.
// ----------------------------------------------------------------------------
module iq_fir_decimator_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400_000;
  // margin for an emitting sample's filter pass to finish
  localparam int SETTLE_CYCLES = ifd_pkg::MAX_TAPS + 16;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    ifd_pkg::sample_t i;
    ifd_pkg::sample_t q;
  } iq_t;

  // one input item plus, for rows that are easy to work out by hand,
  // the filter output typed in directly
  typedef struct packed {
    logic             req;
    ifd_pkg::sample_t si;
    ifd_pkg::sample_t sq;
    logic [5:0]       ci;
    ifd_pkg::coef_t   cv;
    logic             typed;
    ifd_pkg::sample_t ei;
    ifd_pkg::sample_t eq;
  } stim_row_t;

  localparam int DIR_ROWS = 16;

  // Run with decimation 1 and a single tap, so each sample gives
  // round(coef0 * x / 2^15), saturated.
  stim_row_t dir_rows [DIR_ROWS] = '{
    // tap 0 = -1.0; sample fields on a tap write must be ignored
    '{ifd_pkg::REQ_COEF, 16'sh5555, 16'shAAAA, 6'd0, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
    // -x: +full scale maps to -32767, -full scale saturates high;
    // the tap fields of a sample item must be ignored
    '{ifd_pkg::REQ_SAMPLE, 16'sd32767, 16'sh8000, 6'd63, -16'sd1, 1'b1, -16'sd32767,
      16'sd32767},
    '{ifd_pkg::REQ_SAMPLE, 16'sd0, 16'sd1, 6'd0, 16'sd0, 1'b1, 16'sd0, -16'sd1},
    // tap 0 = 0.5: ties round to even
    '{ifd_pkg::REQ_COEF, 16'sd0, 16'sd0, 6'd0, 16'sd16384, 1'b0, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_SAMPLE, 16'sd1, 16'sd3, 6'd0, 16'sd0, 1'b1, 16'sd0, 16'sd2},
    '{ifd_pkg::REQ_SAMPLE, -16'sd1, -16'sd3, 6'd0, 16'sd0, 1'b1, 16'sd0, -16'sd2},
    '{ifd_pkg::REQ_SAMPLE, 16'sd32767, 16'sh8000, 6'd0, 16'sd0, 1'b1, 16'sd16384,
      -16'sd16384},
    // tap 0 = largest positive value
    '{ifd_pkg::REQ_COEF, 16'sd0, 16'sd0, 6'd0, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_SAMPLE, 16'sd32767, 16'sh8000, 6'd0, 16'sd0, 1'b1, 16'sd32766,
      -16'sd32767},
    '{ifd_pkg::REQ_SAMPLE, 16'sd0, 16'sd0, 6'd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
    // tap 0 = smallest step
    '{ifd_pkg::REQ_COEF, 16'sd0, 16'sd0, 6'd0, 16'sd1, 1'b0, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_SAMPLE, 16'sd16384, -16'sd16384, 6'd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_SAMPLE, 16'sh8000, 16'sd32767, 6'd0, 16'sd0, 1'b1, -16'sd1, 16'sd1},
    // writes to taps outside the active window leave the output alone
    '{ifd_pkg::REQ_COEF, 16'shFFFF, 16'sd0, 6'd63, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_COEF, 16'sd0, 16'sd0, 6'd42, -16'sd21846, 1'b0, 16'sd0, 16'sd0},
    '{ifd_pkg::REQ_SAMPLE, 16'sd12345, -16'sd23456, 6'd21, 16'sd0, 1'b0, 16'sd0, 16'sd0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ifd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ifd_pkg::CFG_DATA_W-1:0] cfg_data;

  ifd_in_if  in_ch ();
  ifd_out_if out_ch ();

  iq_fir_decimator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // -- filter predictor state ------------------------------------------------
  ifd_pkg::sample_t line_i [ifd_pkg::MAX_TAPS];
  ifd_pkg::sample_t line_q [ifd_pkg::MAX_TAPS];
  ifd_pkg::coef_t   taps   [ifd_pkg::MAX_TAPS];
  int unsigned      slot_next;
  int unsigned      phase_cnt;
  logic [8:0]       decim_reg;
  logic [6:0]       taps_reg;

  iq_t           expected_iq [$];
  int            outputs_predicted;
  int            mismatch_count;
  int            cycle_count;
  idle_mode_t    idle_mode;
  iq_t           got_iq;
  iq_t           want_iq;

  // Saturate the Q.15 sum to 16 bits, then round to nearest, ties to even.
  function automatic ifd_pkg::sample_t round_sat(longint acc);
    longint hi;
    longint lo;
    longint u;
    longint fl;
    longint rem;
    hi = longint'(32767) <<< ifd_pkg::COEF_FRAC_BITS;
    lo = -(longint'(32768) <<< ifd_pkg::COEF_FRAC_BITS);
    if (acc >= hi) return 16'sd32767;
    if (acc <= lo) return 16'sh8000;
    u   = acc - lo;
    fl  = u >>> ifd_pkg::COEF_FRAC_BITS;
    rem = u & ((longint'(1) <<< ifd_pkg::COEF_FRAC_BITS) - 1);
    if (rem > (longint'(1) <<< (ifd_pkg::COEF_FRAC_BITS - 1)) ||
        (rem == (longint'(1) <<< (ifd_pkg::COEF_FRAC_BITS - 1)) && fl[0]))
      fl++;
    return ifd_pkg::sample_t'(fl - 32768);
  endfunction

  // Push one I/Q pair into the delay lines; returns 1 with the filter
  // output when the pair closes a decimation period.
  function automatic bit filter_sample(ifd_pkg::sample_t xi, ifd_pkg::sample_t xq,
                                       output iq_t y);
    int unsigned n;
    int unsigned m;
    int unsigned rd;
    int unsigned j;
    longint      acc_i;
    longint      acc_q;
    y = '0;
    // out-of-range registers clamp to the nearest legal value
    n = (taps_reg == 0) ? 1 :
        (taps_reg > ifd_pkg::MAX_TAPS) ? ifd_pkg::MAX_TAPS : taps_reg;
    m = (decim_reg == 0) ? 1 :
        (decim_reg > ifd_pkg::MAX_DECIMATION) ? ifd_pkg::MAX_DECIMATION : decim_reg;
    if (slot_next >= ifd_pkg::MAX_TAPS) slot_next = 0;
    line_i[slot_next] = xi;
    line_q[slot_next] = xq;
    // a slot beyond a shrunken window wraps at its next advance
    slot_next = (slot_next + 1 >= n) ? 0 : slot_next + 1;
    phase_cnt++;
    if (phase_cnt < m) return 1'b0;
    phase_cnt = 0;
    rd    = (slot_next == 0) ? n - 1 : slot_next - 1;
    acc_i = 0;
    acc_q = 0;
    for (j = 0; j < n; j++) begin
      acc_i += longint'(taps[j]) * longint'(line_i[rd]);
      acc_q += longint'(taps[j]) * longint'(line_q[rd]);
      rd = (rd == 0) ? n - 1 : rd - 1;
    end
    y.i = round_sat(acc_i);
    y.q = round_sat(acc_q);
    return 1'b1;
  endfunction

  function automatic ifd_pkg::sample_t pick_sample();
    case ($urandom_range(7))
      0:       return 16'sd32767;
      1:       return 16'sh8000;
      2:       return ifd_pkg::sample_t'(int'($urandom_range(511)) - 256);
      default: return ifd_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic ifd_pkg::coef_t pick_coef();
    case ($urandom_range(7))
      0:       return 16'sd32767;
      1:       return 16'sh8000;
      2:       return 16'sd16384;
      3, 4:    return ifd_pkg::coef_t'($urandom);
      default: return ifd_pkg::coef_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t r;
    r       = '0;
    r.req   = ($urandom_range(99) < 12) ? ifd_pkg::REQ_COEF : ifd_pkg::REQ_SAMPLE;
    r.si    = pick_sample();
    r.sq    = pick_sample();
    r.ci    = 6'($urandom_range(63));
    r.cv    = pick_coef();
    r.typed = 1'b0;
    return r;
  endfunction

  // Drive one item, hold it until accepted, then update the predictor.
  task automatic send_item(input stim_row_t row);
    int  idle_pct;
    iq_t y;
    idle_pct = (idle_mode == IDLE_SENDER) ? 49 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= row.req;
    in_ch.sample_i   <= row.si;
    in_ch.sample_q   <= row.sq;
    in_ch.coef_index <= row.ci;
    in_ch.coef_value <= row.cv;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (row.req == ifd_pkg::REQ_COEF) begin
      taps[row.ci] = row.cv;
    end else if (filter_sample(row.si, row.sq, y)) begin
      if (row.typed) begin
        y.i = row.ei;
        y.q = row.eq;
      end
      expected_iq.push_back(y);
      outputs_predicted++;
    end
  endtask

  // Stop sending, let every expected output drain, then give a running
  // filter pass time to finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_iq.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(int decim, int ntaps);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= ifd_pkg::CFG_DECIMATION;
    cfg_data  <= ifd_pkg::CFG_DATA_W'(decim);
    @(posedge clk);
    cfg_index <= ifd_pkg::CFG_TAP_COUNT;
    cfg_data  <= ifd_pkg::CFG_DATA_W'(ntaps);
    @(posedge clk);
    cfg_we    <= 1'b0;
    decim_reg = 9'(decim);
    taps_reg  = 7'(ntaps);
  endtask

  // One setting: random items until both the item count and the wanted
  // number of new outputs are reached.
  task automatic run_phase(int decim, int ntaps, int n_items, int min_out,
                           idle_mode_t mode);
    int k;
    int out_goal;
    write_config(decim, ntaps);
    idle_mode = mode;
    out_goal  = outputs_predicted + min_out;
    k         = 0;
    while (k < n_items || outputs_predicted < out_goal) begin
      send_item(random_item());
      k++;
    end
  endtask

  // -- clock -----------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -- run-away guard ---------------------------------------------------------
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d outputs still expected", $time, expected_iq.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // -- receiver: stalls at random depending on the idle mode -------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (idle_mode)
        IDLE_RECEIVER: out_ch.ready <= ($urandom_range(99) >= 49);
        IDLE_BOTH:     out_ch.ready <= ($urandom_range(99) >= 8);
        default:       out_ch.ready <= 1'b1;
      endcase
    end
  end

  // -- output checker: oldest expectation first --------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_iq.i = out_ch.out_i;
      got_iq.q = out_ch.out_q;
      if (expected_iq.size() == 0) begin
        $display("%0t: output with nothing expected: i=%0d q=%0d",
                 $time, got_iq.i, got_iq.q);
        mismatch_count++;
      end else begin
        want_iq = expected_iq.pop_front();
        if (got_iq.i !== want_iq.i) begin
          $display("%0t: out_i expected %0d, got %0d", $time, want_iq.i, got_iq.i);
          mismatch_count++;
        end
        if (got_iq.q !== want_iq.q) begin
          $display("%0t: out_q expected %0d, got %0d", $time, want_iq.q, got_iq.q);
          mismatch_count++;
        end
      end
    end
  end

  // -- stimulus ----------------------------------------------------------------
  initial begin
    int r;
    int t;
    stim_row_t row;

    // delay lines start empty; taps are only read after being written
    for (t = 0; t < ifd_pkg::MAX_TAPS; t++) begin
      line_i[t] = '0;
      line_q[t] = '0;
      taps[t]   = '0;
    end
    slot_next         = 0;
    phase_cnt         = 0;
    decim_reg         = 9'd1;
    taps_reg          = 7'd64;
    outputs_predicted = 0;
    mismatch_count    = 0;
    idle_mode         = IDLE_NONE;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= ifd_pkg::CFG_DECIMATION;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= ifd_pkg::REQ_SAMPLE;
    in_ch.sample_i   <= '0;
    in_ch.sample_q   <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table with one tap and no decimation
    write_config(1, 1);
    for (r = 0; r < DIR_ROWS; r++) send_item(dir_rows[r]);

    // fill every tap so any later window size reads written entries only
    idle_mode = IDLE_BOTH;
    for (t = 0; t < ifd_pkg::MAX_TAPS; t++) begin
      row    = random_item();
      row.req = ifd_pkg::REQ_COEF;
      row.ci = 6'(t);
      send_item(row);
    end

    // Settings step through the register extremes; leftover phase counts
    // and write slots from one setting carry into the next one.
    run_phase(1,   64,  80, 0, IDLE_NONE);
    run_phase(4,   16,  80, 0, IDLE_SENDER);
    run_phase(0,   0,   50, 0, IDLE_RECEIVER);
    run_phase(3,   127, 60, 0, IDLE_BOTH);
    run_phase(9,   2,   50, 0, IDLE_SENDER);
    run_phase(511, 40,  20, 1, IDLE_RECEIVER);
    run_phase(2,   64,  80, 0, IDLE_BOTH);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== iq_fir_decimator_top.f =====
hw/rtl/ifd_pkg.sv
hw/rtl/ifd_in_if.sv
hw/rtl/ifd_out_if.sv
hw/rtl/ifd_ram.sv
hw/rtl/ifd_ctrl.sv
hw/rtl/ifd_datapath.sv
hw/rtl/iq_fir_decimator_top.sv
test/iq_fir_decimator_top_test.sv
